FILE: src/gauge_level_smoother_unit_assert.svh
// Assertion macros for the gauge level smoother checks.
`ifndef GAUGE_LEVEL_SMOOTHER_UNIT_ASSERT_SVH
`define GAUGE_LEVEL_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define GLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gauge_level_smoother_unit: check failed");

// Next-cycle implication, disabled while in reset.
`define GLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gauge_level_smoother_unit: check failed");

`endif

FILE: src/gls_pkg.sv
// Package: types and constants of the gauge level smoother.
package gls_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NEEDLE_W   = FRAC_BITS + 7;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int SPAN_W     = 33;
    localparam int PCT_W      = SPAN_W + 7;
    localparam int ACC_W      = ALPHA_W + NEEDLE_W;
    localparam int CNT_W      = $clog2(NEEDLE_W + 1);

    localparam logic [NEEDLE_W-1:0] FULL_SCALE = NEEDLE_W'(100 << FRAC_BITS);
    localparam logic [NEEDLE_W-1:0] TENTH      = NEEDLE_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = ALPHA_W'(1 << ALPHA_FRAC);
    localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(1 << (ALPHA_FRAC - 1));

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] CFG_SPAN_LOW  = 3'd0;
    localparam logic [2:0] CFG_SPAN_HIGH = 3'd1;
    localparam logic [2:0] CFG_ALPHA     = 3'd2;
    localparam logic [2:0] CFG_CRIT_LOW  = 3'd3;
    localparam logic [2:0] CFG_CRIT_HIGH = 3'd4;
    localparam logic [2:0] CFG_WARN_LOW  = 3'd5;
    localparam logic [2:0] CFG_WARN_HIGH = 3'd6;
    localparam logic [2:0] CFG_ENABLES   = 3'd7;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] reading;
    } t_in_item;

    typedef struct packed {
        logic [NEEDLE_W-1:0] needle_percent;
        logic                reading_valid;
        logic                critical_flag;
        logic                warning_flag;
        logic                session_valid;
        logic signed [31:0]  session_low;
        logic signed [31:0]  session_high;
    } t_out_item;

endpackage

FILE: src/gauge_level_smoother_unit.sv
// Top level: gauge level smoother with session min/max and limit alarms.
//
// Input channel (i_in_valid / o_in_stall) carries a mode and a Q16.16 reading:
// a reading, a tick without reading, or a session clear. One result per item
// leaves on the output channel (o_out_valid / i_out_stall).
// Configuration writes (i_cfg_valid / o_cfg_ready, index, data) are taken in
// any cycle and must only be issued while the block is idle.
// A reading inside the span passes from accept to result through a setup step, the
// clamp of the percentage, the restoring divider (one quotient bit per cycle), the
// MULA and MULK steps on the shared 17x23 multiplier, a snap step and the load of
// the output register. Readings outside the span skip the divider, ticks go from
// setup to MULK, and clears go from setup straight to the output load.
// The next item can be taken in the cycle after the result loads.
// o_in_stall is high while an item is in flight; a new item can be taken
// while the previous result still waits in the output register.
// When the receiver stalls, the result holds and the next item stops before
// its output load until the register frees up.
// Reset restores the configuration defaults and clears level and session.
module gauge_level_smoother_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gls_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gls_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import gls_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_CLMP = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_MULA = 7'b0010000,
        S_MULK = 7'b0100000,
        S_SNAP = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    logic signed [31:0] r_span_low, r_span_high;
    logic [ALPHA_W-1:0] r_alpha;
    logic signed [31:0] r_crit_low, r_crit_high, r_warn_low, r_warn_high;
    logic [3:0]         r_enables;

    logic [NEEDLE_W-1:0] r_level;
    logic signed [31:0]  r_low_seen, r_high_seen;
    logic                r_seen;

    logic [1:0]             r_mode;
    logic                   r_crit, r_warn;
    logic signed [SPAN_W-1:0] r_range, r_num;
    logic [SPAN_W-1:0]      r_rem;
    logic [NEEDLE_W-1:0]    r_dq;
    logic [CNT_W-1:0]       r_cnt;
    logic [ACC_W-1:0]       r_acc;

    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                  accept;
    logic                  is_read;
    logic                  out_free;
    logic [ALPHA_W-1:0]    alpha_sat, keep;
    logic [PCT_W-1:0]      num_x100;
    logic [SPAN_W:0]       div_trial, div_range;
    logic                  div_ge;
    logic [ALPHA_W-1:0]    mul_x;
    logic [NEEDLE_W-1:0]   mul_y;
    logic [ACC_W-1:0]      product;
    logic [NEEDLE_W-1:0]   s_new, s_diff;
    logic                  crit_hit, warn_hit;
    logic signed [31:0]    rd;

    assign rd       = i_in_item.reading;
    assign accept   = i_in_valid && !o_in_stall;
    assign is_read  = (r_mode == MODE_READ);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE) || r_done;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign alpha_sat = r_alpha[ALPHA_W-1] ? ALPHA_ONE : r_alpha;
    assign keep      = ALPHA_ONE - alpha_sat;

    assign num_x100 = (PCT_W'(r_num) << 6) + (PCT_W'(r_num) << 5) + (PCT_W'(r_num) << 2);

    assign div_trial = {r_rem, r_dq[NEEDLE_W-1]};
    assign div_range = {1'b0, r_range};
    assign div_ge    = (div_trial >= div_range);

    assign mul_x   = (r_state == S_MULA) ? alpha_sat : keep;
    assign mul_y   = (r_state == S_MULA) ? r_dq : r_level;
    assign product = ACC_W'(mul_x) * ACC_W'(mul_y);

    assign s_new  = r_acc[ALPHA_FRAC +: NEEDLE_W];
    assign s_diff = (s_new > r_dq) ? (s_new - r_dq) : (r_dq - s_new);

    assign crit_hit = (r_enables[0] && rd <= r_crit_low) || (r_enables[1] && rd >= r_crit_high);
    assign warn_hit = (r_enables[2] && rd <= r_warn_low) || (r_enables[3] && rd >= r_warn_high);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_PREP;
            S_PREP: begin
                if (r_mode == MODE_CLEAR) n_state = S_IDLE;
                else if (is_read)         n_state = S_CLMP;
                else                      n_state = S_MULK;
            end
            S_CLMP: begin
                if (r_range <= 0 || r_num <= 0 || r_num >= r_range) n_state = S_MULA;
                else                                                n_state = S_DIV;
            end
            S_DIV:  if (r_cnt == CNT_W'(NEEDLE_W - 1)) n_state = S_MULA;
            S_MULA: n_state = S_MULK;
            S_MULK: n_state = S_SNAP;
            S_SNAP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_low  <= '0;
            r_span_high <= 32'sd6553600;
            r_alpha     <= ALPHA_W'(19661);
            r_crit_low  <= '0;
            r_crit_high <= '0;
            r_warn_low  <= '0;
            r_warn_high <= '0;
            r_enables   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPAN_LOW:  r_span_low  <= i_cfg_data;
                CFG_SPAN_HIGH: r_span_high <= i_cfg_data;
                CFG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_CRIT_LOW:  r_crit_low  <= i_cfg_data;
                CFG_CRIT_HIGH: r_crit_high <= i_cfg_data;
                CFG_WARN_LOW:  r_warn_low  <= i_cfg_data;
                CFG_WARN_HIGH: r_warn_high <= i_cfg_data;
                CFG_ENABLES:   r_enables   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_level     <= '0;
            r_low_seen  <= '0;
            r_high_seen <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_in_item.mode;
                        r_range <= SPAN_W'(r_span_high) - SPAN_W'(r_span_low);
                        r_num   <= SPAN_W'(rd) - SPAN_W'(r_span_low);
                        r_crit  <= (i_in_item.mode == MODE_READ) && crit_hit;
                        r_warn  <= (i_in_item.mode == MODE_READ) && warn_hit;
                        if (i_in_item.mode == MODE_READ) begin
                            if (!r_seen || rd < r_low_seen)  r_low_seen  <= rd;
                            if (!r_seen || rd > r_high_seen) r_high_seen <= rd;
                            r_seen <= 1'b1;
                        end else if (i_in_item.mode == MODE_CLEAR) begin
                            r_low_seen  <= '0;
                            r_high_seen <= '0;
                            r_seen      <= 1'b0;
                        end
                    end
                end
                S_PREP: begin
                    r_acc <= ROUND_HALF;
                    r_cnt <= '0;
                    if (r_mode == MODE_CLEAR) begin
                        r_level <= '0;
                        r_done  <= 1'b1;
                    end
                end
                S_CLMP: begin
                    r_rem <= num_x100[PCT_W-1:7];
                    if (r_range <= 0 || r_num <= 0) r_dq <= '0;
                    else if (r_num >= r_range)      r_dq <= FULL_SCALE;
                    else                            r_dq <= {num_x100[6:0], {FRAC_BITS{1'b0}}};
                end
                S_DIV: begin
                    r_rem <= div_ge ? SPAN_W'(div_trial - div_range) : div_trial[SPAN_W-1:0];
                    r_dq  <= {r_dq[NEEDLE_W-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                S_MULA, S_MULK: begin
                    r_acc <= r_acc + product;
                end
                S_SNAP: begin
                    r_done <= 1'b1;
                    if (is_read) r_level <= (s_diff < TENTH) ? r_dq : s_new;
                    else         r_level <= (s_new < TENTH) ? '0 : s_new;
                end
                default: ;
            endcase

            // result goes out once the output register is free
            if (r_done && out_free) begin
                r_done      <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_item.needle_percent <= r_level;
                r_out_item.reading_valid  <= is_read;
                r_out_item.critical_flag  <= r_crit;
                r_out_item.warning_flag   <= r_warn;
                r_out_item.session_valid  <= r_seen;
                r_out_item.session_low    <= r_low_seen;
                r_out_item.session_high   <= r_high_seen;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/gls_chk.sv
// Checker for the gauge level smoother ports, with its bind.
module gls_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input gls_pkg::t_out_item o_out_item
);
    import gls_pkg::*;
`include "gauge_level_smoother_unit_assert.svh"

    `GLS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `GLS_ASSERT_NOW(a_needle_range, i_clk, i_rst_n, o_out_valid, o_out_item.needle_percent <= FULL_SCALE)
    `GLS_ASSERT_NOW(a_flags_need_reading, i_clk, i_rst_n, o_out_valid && !o_out_item.reading_valid, !o_out_item.critical_flag && !o_out_item.warning_flag)
    `GLS_ASSERT_NOW(a_reading_opens_session, i_clk, i_rst_n, o_out_valid && o_out_item.reading_valid, o_out_item.session_valid && o_out_item.session_low <= o_out_item.session_high)
    `GLS_ASSERT_NOW(a_empty_session_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.session_valid, o_out_item.session_low == 0 && o_out_item.session_high == 0)

endmodule

bind gauge_level_smoother_unit gls_chk u_gls_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item)
);

FILE: sim/tb.sv
// Testbench for gauge_level_smoother_unit: directed and random transactions checked against a predictor.
module tb;
    import gls_pkg::*;

    localparam logic [1:0]      MODE_SPARE     = 2'd3;
    localparam longint          FULL_PCT       = 64'd100 << 16;
    localparam longint          TENTH_PCT      = ((64'd1 << 16) + 5) / 10;
    localparam longint          ALPHA_UNIT     = 64'd65536;
    localparam int              WATCHDOG_LIMIT = 4000;
    localparam int              DRAIN_CYCLES   = 40;
    localparam int              HOLD_AT        = 60;
    localparam int              HOLD_LEN       = 400;
    localparam int              PHASE_ITEMS    = 64;
    localparam int              RANDOM_PHASES  = 7;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        o_cfg_ready;

    gauge_level_smoother_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers and state
    logic signed [31:0] span_lo  = 32'sd0;
    logic signed [31:0] span_hi  = 32'sd6553600;
    logic [16:0]        alpha_w  = 17'd19661;
    logic signed [31:0] crit_lo  = 32'sd0;
    logic signed [31:0] crit_hi  = 32'sd0;
    logic signed [31:0] warn_lo  = 32'sd0;
    logic signed [31:0] warn_hi  = 32'sd0;
    logic [3:0]         limit_en = 4'd0;
    logic [22:0]        needle_level = '0;
    logic signed [31:0] low_mark  = 32'sd0;
    logic signed [31:0] high_mark = 32'sd0;
    logic               have_reading = 1'b0;

    t_in_item  pending_readings[$];
    t_out_item expected_needles[$];
    logic signed [31:0] last_reading = 32'sd0;
    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int errors = 0;
    int results_checked = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic longint span_percent(logic signed [31:0] rd);
        longint span, num;
        span = longint'(span_hi) - longint'(span_lo);
        num  = longint'(rd) - longint'(span_lo);
        if (span <= 0 || num <= 0) return 0;
        if (num >= span) return FULL_PCT;
        return (num * FULL_PCT) / span;
    endfunction

    function automatic t_out_item advance_gauge(t_in_item it);
        t_out_item r;
        longint a, keep, p, acc, diff;
        r = '0;
        a = (alpha_w > 17'd65536) ? ALPHA_UNIT : longint'(alpha_w);
        keep = ALPHA_UNIT - a;
        case (it.mode)
            MODE_READ: begin
                p = span_percent(it.reading);
                if (!have_reading || it.reading < low_mark) low_mark = it.reading;
                if (!have_reading || it.reading > high_mark) high_mark = it.reading;
                have_reading = 1'b1;
                acc = (a * p + keep * longint'(needle_level) + 32768) >>> 16;
                diff = (acc > p) ? acc - p : p - acc;
                needle_level = (diff < TENTH_PCT) ? p[22:0] : acc[22:0];
                r.reading_valid = 1'b1;
                r.critical_flag = (limit_en[0] && it.reading <= crit_lo) ||
                                  (limit_en[1] && it.reading >= crit_hi);
                r.warning_flag  = (limit_en[2] && it.reading <= warn_lo) ||
                                  (limit_en[3] && it.reading >= warn_hi);
            end
            MODE_CLEAR: begin
                needle_level = '0;
                low_mark = '0;
                high_mark = '0;
                have_reading = 1'b0;
            end
            default: begin
                acc = (keep * longint'(needle_level) + 32768) >>> 16;
                needle_level = (acc < TENTH_PCT) ? '0 : acc[22:0];
            end
        endcase
        r.needle_percent = needle_level;
        r.session_valid  = have_reading;
        r.session_low    = have_reading ? low_mark : '0;
        r.session_high   = have_reading ? high_mark : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_needles.push_back(advance_gauge(i_in_item));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_readings.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_readings.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_needles.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    errors++;
                end else begin
                    want = expected_needles.pop_front();
                    check_field("needle_percent", want.needle_percent, o_out_item.needle_percent);
                    check_field("reading_valid", want.reading_valid, o_out_item.reading_valid);
                    check_field("critical_flag", want.critical_flag, o_out_item.critical_flag);
                    check_field("warning_flag", want.warning_flag, o_out_item.warning_flag);
                    check_field("session_valid", want.session_valid, o_out_item.session_valid);
                    check_field("session_low", want.session_low, o_out_item.session_low);
                    check_field("session_high", want.session_high, o_out_item.session_high);
                end
                results_checked++;
                if (results_checked == HOLD_AT) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) hold_left--;
            i_out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** gauge_level_smoother_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SPAN_LOW:  span_lo  = data;
            CFG_SPAN_HIGH: span_hi  = data;
            CFG_ALPHA:     alpha_w  = data[16:0];
            CFG_CRIT_LOW:  crit_lo  = data;
            CFG_CRIT_HIGH: crit_hi  = data;
            CFG_WARN_LOW:  warn_lo  = data;
            CFG_WARN_HIGH: warn_hi  = data;
            CFG_ENABLES:   limit_en = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] lo, logic [31:0] hi, logic [31:0] al,
                            logic [31:0] cl, logic [31:0] ch, logic [31:0] wl,
                            logic [31:0] wh, logic [31:0] en);
        write_reg(CFG_SPAN_LOW, lo);
        write_reg(CFG_SPAN_HIGH, hi);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_CRIT_LOW, cl);
        write_reg(CFG_CRIT_HIGH, ch);
        write_reg(CFG_WARN_LOW, wl);
        write_reg(CFG_WARN_HIGH, wh);
        write_reg(CFG_ENABLES, en);
        @(negedge i_clk);
    endtask

    task automatic queue_item(logic [1:0] m, logic signed [31:0] rd);
        t_in_item it;
        it.mode = m;
        it.reading = rd;
        pending_readings.push_back(it);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(negedge i_clk);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_readings.size() != 0 || expected_needles.size() != 0 || i_in_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned spread;
        spread = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} % spread);
    endfunction

    function automatic logic signed [31:0] pick_reading();
        longint lo, hi, w;
        int sel;
        lo = (span_lo < span_hi) ? longint'(span_lo) : longint'(span_hi);
        hi = (span_lo < span_hi) ? longint'(span_hi) : longint'(span_lo);
        w = hi - lo;
        sel = $urandom_range(99);
        if (sel < 10) return $urandom;
        if (sel < 20) begin
            case ($urandom_range(3))
                0: return crit_lo;
                1: return crit_hi;
                2: return warn_lo;
                default: return warn_hi;
            endcase
        end
        if (sel < 45) return last_reading;
        return clip32(pick_between(lo - w / 8 - 65536, hi + w / 8 + 65536));
    endfunction

    task automatic random_regs();
        longint lo, hi, tmp, mn, mx, w;
        logic [31:0] al, en;
        int kind;
        kind = $urandom_range(9);
        lo = (longint'($urandom_range(600)) - 300) * 65536 + longint'($urandom_range(65535));
        hi = lo + (longint'($urandom_range(400)) + 1) * 65536 + longint'($urandom_range(65535));
        case (kind)
            0: begin
                lo = longint'($signed($urandom));
                hi = longint'($signed($urandom));
            end
            1: hi = lo;
            2: begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            3: begin
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end
            default: ;
        endcase
        mn = (lo < hi) ? lo : hi;
        mx = (lo < hi) ? hi : lo;
        w = mx - mn;
        case ($urandom_range(5))
            0: al = 32'd0;
            1: al = 32'd65536;
            2: al = $urandom;
            3: al = $urandom_range(131071, 65537);
            default: al = $urandom_range(65536, 4000);
        endcase
        en = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
        set_regs(clip32(lo), clip32(hi), al,
                 clip32(pick_between(mn - w / 4, mx + w / 4)),
                 clip32(pick_between(mn - w / 4, mx + w / 4)),
                 clip32(pick_between(mn - w / 4, mx + w / 4)),
                 clip32(pick_between(mn - w / 4, mx + w / 4)), en);
    endtask

    task automatic queue_random(int n);
        int k, sel, run;
        logic signed [31:0] rd;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                rd = pick_reading();
                last_reading = rd;
                queue_item(MODE_READ, rd);
            end else if (sel < 85) begin
                run = $urandom_range(8, 1);
                repeat (run) queue_item(MODE_TICK, $urandom);
            end else if (sel < 90) begin
                queue_item(MODE_CLEAR, $urandom);
            end else begin
                queue_item(MODE_SPARE, $urandom);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(22, 66);

        // reset defaults: span 0..100, all limits off
        queue_item(MODE_READ, 50 * 65536);
        queue_item(MODE_READ, 50 * 65536);
        queue_item(MODE_READ, 32'h7FFF_FFFF);
        queue_item(MODE_READ, 32'h8000_0000);
        queue_item(MODE_TICK, 32'hFFFF_FFFF);
        queue_item(MODE_SPARE, 32'h0);
        queue_item(MODE_CLEAR, 32'h5A5A_A5A5);
        queue_item(MODE_TICK, 32'h0);
        wait_drained();

        // alpha of one, all four limits hit exactly
        set_regs(-10 * 65536, 90 * 65536, 32'd65536, -5 * 65536, 80 * 65536,
                 32'd0, 60 * 65536, 32'hF);
        queue_item(MODE_READ, -5 * 65536);
        queue_item(MODE_READ, 80 * 65536);
        queue_item(MODE_READ, 60 * 65536);
        queue_item(MODE_READ, 32'h0);
        queue_item(MODE_READ, -10 * 65536);
        queue_item(MODE_READ, 90 * 65536);
        queue_item(MODE_READ, 32'h1);
        queue_item(MODE_TICK, 32'h0);
        wait_drained();

        // zero-width span, alpha above one with upper data bits set
        set_regs(5 * 65536, 5 * 65536, 32'hFFFF_FFFF, 5 * 65536, 5 * 65536,
                 5 * 65536, 5 * 65536, 32'hFFFF_FFF5);
        queue_item(MODE_READ, 6 * 65536);
        queue_item(MODE_READ, 4 * 65536);
        queue_item(MODE_READ, 5 * 65536);
        wait_drained();

        // full 32-bit span, alpha zero
        set_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h1, 32'hA);
        queue_item(MODE_READ, 32'h0);
        queue_item(MODE_READ, 32'h7FFF_FFFF);
        queue_item(MODE_READ, 32'h8000_0000);
        queue_item(MODE_TICK, 32'h0);
        queue_item(MODE_CLEAR, 32'h0);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_regs();
            if (ph < 3) set_idling(22, 66);
            else if (ph < 5) set_idling(66, 22);
            else set_idling(0, 0);
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        if (errors == 0) begin
            $display("** gauge_level_smoother_unit: PASSED **");
        end else begin
            $display("** gauge_level_smoother_unit: FAILED **");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/gls_pkg.sv
src/gauge_level_smoother_unit.sv
src/gls_chk.sv
sim/tb.sv
